// File: rtl/core/mctm_pkg.sv
// Shared types and constants of the MIDI clock tempo monitor.
`default_nettype none

package mctm_pkg;

   // Field and datapath widths
   localparam int TYPE_W     = 4;
   localparam int CHAN_W     = 4;
   localparam int DATA_W     = 8;
   localparam int VALUE_W    = 16;
   localparam int TIME_W     = 32;
   localparam int COUNT_W    = 32;
   localparam int TEMPO_W    = 14;
   localparam int PERIOD_W   = 18;
   localparam int IIR_W      = PERIOD_W + 3;
   localparam int DIVISOR_W  = PERIOD_W + 5;
   localparam int DIVIDEND_W = 30;
   localparam int STEP_W     = $clog2(DIVIDEND_W);

   // Command codes
   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // Event type codes
   localparam logic [TYPE_W-1:0] TYPE_NONE  = 4'd0;
   localparam logic [TYPE_W-1:0] TYPE_CLOCK = 4'd1;

   // Interval filter and tempo constants
   localparam logic [TIME_W-1:0]     MIN_INTERVAL_US    = 32'd5000;
   localparam logic [TIME_W-1:0]     MAX_INTERVAL_US    = 32'd200000;
   localparam logic [DIVIDEND_W-1:0] TEMPO_DIVIDEND     = 30'd600000000;
   localparam logic [TEMPO_W-1:0]    TEMPO_MAX          = 14'd9999;
   localparam logic [TIME_W-1:0]     PRESENT_WINDOW_MS  = 32'd500;
   localparam logic [TIME_W-1:0]     ACTIVITY_WINDOW_MS = 32'd140;
   localparam logic [TIME_W-1:0]     AGE_NONE           = 32'hFFFF_FFFF;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic update;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_last;
   } sts_type;

endpackage

`default_nettype wire

// File: rtl/core/mctm_ctrl.sv
// Sequencing state machine and result handshake of the tempo monitor.
`default_nettype none

module mctm_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output mctm_pkg::cmd_type    cmd,
   input  wire mctm_pkg::sts_type sts
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UPDATE = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_DIVIDE = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Decode state into datapath commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_LOAD;
         end
         S_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIVIDE;
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result word until it is taken
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/mctm_datapath.sv
// Event state, period filter, tempo divider and snapshot register.
`default_nettype none

module mctm_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire mctm_pkg::cmd_type                     cmd,
   output mctm_pkg::sts_type                          sts,
   input  wire logic                                  csr_valid,
   input  wire logic                                  csr_show_clock_events,
   input  wire logic                                  req_command,
   input  wire logic [mctm_pkg::TYPE_W-1:0]           req_event_type,
   input  wire logic [mctm_pkg::CHAN_W-1:0]           req_channel,
   input  wire logic [mctm_pkg::DATA_W-1:0]           req_data_byte,
   input  wire logic signed [mctm_pkg::VALUE_W-1:0]   req_event_value,
   input  wire logic [mctm_pkg::TIME_W-1:0]           req_now_ms,
   input  wire logic [mctm_pkg::TIME_W-1:0]           req_now_us,
   output logic [mctm_pkg::TYPE_W-1:0]                rsp_shown_type,
   output logic [mctm_pkg::CHAN_W-1:0]                rsp_shown_channel,
   output logic [mctm_pkg::DATA_W-1:0]                rsp_shown_data,
   output logic signed [mctm_pkg::VALUE_W-1:0]        rsp_shown_value,
   output logic [mctm_pkg::COUNT_W-1:0]               rsp_event_count,
   output logic [mctm_pkg::TIME_W-1:0]                rsp_event_time_ms,
   output logic [mctm_pkg::COUNT_W-1:0]               rsp_clock_count,
   output logic [mctm_pkg::TIME_W-1:0]                rsp_clock_age_ms,
   output logic                                       rsp_clock_present,
   output logic [mctm_pkg::TEMPO_W-1:0]               rsp_tempo_tenths_bpm,
   output logic                                       rsp_activity_recent
);

   // Configuration
   logic show_clock_ff;

   // Captured request word
   logic                                cmd_ff;
   logic [mctm_pkg::TYPE_W-1:0]         type_ff;
   logic [mctm_pkg::CHAN_W-1:0]         chan_ff;
   logic [mctm_pkg::DATA_W-1:0]         data_ff;
   logic signed [mctm_pkg::VALUE_W-1:0] value_ff;
   logic [mctm_pkg::TIME_W-1:0]         now_ms_ff;
   logic [mctm_pkg::TIME_W-1:0]         now_us_ff;

   // Monitor state
   logic [mctm_pkg::TYPE_W-1:0]         lat_type_ff;
   logic [mctm_pkg::CHAN_W-1:0]         lat_chan_ff;
   logic [mctm_pkg::DATA_W-1:0]         lat_data_ff;
   logic signed [mctm_pkg::VALUE_W-1:0] lat_value_ff;
   logic [mctm_pkg::COUNT_W-1:0]        lat_count_ff;
   logic [mctm_pkg::TIME_W-1:0]         lat_time_ff;
   logic [mctm_pkg::TIME_W-1:0]         act_time_ff;
   logic [mctm_pkg::COUNT_W-1:0]        clocks_ff;
   logic [mctm_pkg::TIME_W-1:0]         last_us_ff;
   logic [mctm_pkg::TIME_W-1:0]         last_ms_ff;
   logic [mctm_pkg::PERIOD_W-1:0]       period_ff;

   // Divider
   logic [mctm_pkg::DIVISOR_W-1:0]      divisor_ff;
   logic [mctm_pkg::DIVISOR_W-1:0]      rem_ff;
   logic [mctm_pkg::DIVIDEND_W-1:0]     quo_ff;
   logic [mctm_pkg::STEP_W-1:0]         step_ff;

   // Update terms
   logic                                is_clock;
   logic                                do_latch;
   logic [mctm_pkg::TIME_W-1:0]         delta;
   logic                                in_range;
   logic [mctm_pkg::IIR_W-1:0]          iir_sum;
   logic [mctm_pkg::PERIOD_W-1:0]       period_in;

   // Divider terms
   logic [mctm_pkg::DIVISOR_W:0]        rem_shift;
   logic [mctm_pkg::DIVISOR_W+1:0]      trial;
   logic [mctm_pkg::DIVISOR_W-1:0]      divisor_in;

   // Snapshot terms
   logic [mctm_pkg::TIME_W-1:0]         age_in;
   logic                                present_in;
   logic [mctm_pkg::TIME_W-1:0]         act_age;
   logic                                active_in;
   logic [mctm_pkg::TEMPO_W-1:0]        tempo_sat;
   logic [mctm_pkg::TEMPO_W-1:0]        tempo_in;

   // Interval measurement and 7/8 smoothing
   assign is_clock  = (type_ff == mctm_pkg::TYPE_CLOCK);
   assign do_latch  = !is_clock || show_clock_ff;
   assign delta     = now_us_ff - last_us_ff;
   assign in_range  = (delta >= mctm_pkg::MIN_INTERVAL_US)
                   && (delta <= mctm_pkg::MAX_INTERVAL_US);
   assign iir_sum   = {period_ff, 3'b000} - {3'b000, period_ff}
                    + {3'b000, delta[mctm_pkg::PERIOD_W-1:0]};
   assign period_in = (period_ff == '0) ? delta[mctm_pkg::PERIOD_W-1:0]
                                        : iir_sum[mctm_pkg::IIR_W-1:3];

   // Divisor is period times 24
   assign divisor_in = {1'b0, period_ff, 4'b0000} + {2'b00, period_ff, 3'b000};

   // One restoring division step
   assign rem_shift = {rem_ff, quo_ff[mctm_pkg::DIVIDEND_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, divisor_ff};

   assign sts.div_last = (step_ff == mctm_pkg::STEP_W'(mctm_pkg::DIVIDEND_W - 1));

   // Snapshot of clock age, presence, tempo and activity
   assign age_in     = (last_ms_ff != '0) ? (now_ms_ff - last_ms_ff) : mctm_pkg::AGE_NONE;
   assign present_in = (last_ms_ff != '0) && (age_in < mctm_pkg::PRESENT_WINDOW_MS);
   assign tempo_sat  = (quo_ff > mctm_pkg::DIVIDEND_W'(mctm_pkg::TEMPO_MAX))
                     ? mctm_pkg::TEMPO_MAX : quo_ff[mctm_pkg::TEMPO_W-1:0];
   assign tempo_in   = (present_in && (period_ff != '0)) ? tempo_sat : '0;
   assign act_age    = now_ms_ff - act_time_ff;
   assign active_in  = (act_time_ff != '0) && (act_age < mctm_pkg::ACTIVITY_WINDOW_MS);

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         show_clock_ff <= 1'b0;
      end else if (csr_valid) begin
         show_clock_ff <= csr_show_clock_events;
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff    <= req_command;
         type_ff   <= req_event_type;
         chan_ff   <= req_channel;
         data_ff   <= req_data_byte;
         value_ff  <= req_event_value;
         now_ms_ff <= req_now_ms;
         now_us_ff <= req_now_us;
      end
   end

   // Apply a recorded event to the monitor state
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_type_ff  <= '0;
         lat_chan_ff  <= '0;
         lat_data_ff  <= '0;
         lat_value_ff <= '0;
         lat_count_ff <= '0;
         lat_time_ff  <= '0;
         act_time_ff  <= '0;
         clocks_ff    <= '0;
         last_us_ff   <= '0;
         last_ms_ff   <= '0;
         period_ff    <= '0;
      end else if (cmd.update && (cmd_ff == mctm_pkg::CMD_RECORD)) begin
         if (is_clock) begin
            if ((last_us_ff != '0) && in_range) begin
               period_ff <= period_in;
            end
            last_us_ff <= now_us_ff;
            last_ms_ff <= now_ms_ff;
            clocks_ff  <= clocks_ff + 1'b1;
         end
         if (do_latch) begin
            lat_type_ff  <= type_ff;
            lat_chan_ff  <= chan_ff;
            lat_data_ff  <= data_ff;
            lat_value_ff <= value_ff;
            lat_count_ff <= lat_count_ff + 1'b1;
            lat_time_ff  <= now_ms_ff;
            if ((type_ff != mctm_pkg::TYPE_NONE) && !is_clock) begin
               act_time_ff <= now_ms_ff;
            end
         end
      end
   end

   // Step counter of the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.div_load) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + 1'b1;
      end
   end

   // Tempo divider: one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         divisor_ff <= divisor_in;
         rem_ff     <= '0;
         quo_ff     <= mctm_pkg::TEMPO_DIVIDEND;
      end else if (cmd.div_step) begin
         if (!trial[mctm_pkg::DIVISOR_W+1]) begin
            rem_ff <= trial[mctm_pkg::DIVISOR_W-1:0];
         end else begin
            rem_ff <= rem_shift[mctm_pkg::DIVISOR_W-1:0];
         end
         quo_ff <= {quo_ff[mctm_pkg::DIVIDEND_W-2:0], !trial[mctm_pkg::DIVISOR_W+1]};
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_shown_type       <= lat_type_ff;
         rsp_shown_channel    <= lat_chan_ff;
         rsp_shown_data       <= lat_data_ff;
         rsp_shown_value      <= lat_value_ff;
         rsp_event_count      <= lat_count_ff;
         rsp_event_time_ms    <= lat_time_ff;
         rsp_clock_count      <= clocks_ff;
         rsp_clock_age_ms     <= age_in;
         rsp_clock_present    <= present_in;
         rsp_tempo_tenths_bpm <= tempo_in;
         rsp_activity_recent  <= active_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/midi_clock_tempo_monitor.sv
// MIDI clock tempo monitor: 7/8 smoothed clock period, tempo and activity snapshot.
// Each accepted request is captured, applied to the state, the divider loaded,
// run through the 30-step tempo divider and its result loaded; the result load
// waits until the previous response is taken. A new request is accepted only after
// the previous result is loaded, even while that response still waits in its register.
// Reset (synchronous, active high) clears all event and clock state and the config.
`default_nettype none

module midi_clock_tempo_monitor (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic                                  csr_show_clock_events,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_command,
   input  wire logic [mctm_pkg::TYPE_W-1:0]           req_event_type,
   input  wire logic [mctm_pkg::CHAN_W-1:0]           req_channel,
   input  wire logic [mctm_pkg::DATA_W-1:0]           req_data_byte,
   input  wire logic signed [mctm_pkg::VALUE_W-1:0]   req_event_value,
   input  wire logic [mctm_pkg::TIME_W-1:0]           req_now_ms,
   input  wire logic [mctm_pkg::TIME_W-1:0]           req_now_us,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [mctm_pkg::TYPE_W-1:0]                rsp_shown_type,
   output logic [mctm_pkg::CHAN_W-1:0]                rsp_shown_channel,
   output logic [mctm_pkg::DATA_W-1:0]                rsp_shown_data,
   output logic signed [mctm_pkg::VALUE_W-1:0]        rsp_shown_value,
   output logic [mctm_pkg::COUNT_W-1:0]               rsp_event_count,
   output logic [mctm_pkg::TIME_W-1:0]                rsp_event_time_ms,
   output logic [mctm_pkg::COUNT_W-1:0]               rsp_clock_count,
   output logic [mctm_pkg::TIME_W-1:0]                rsp_clock_age_ms,
   output logic                                       rsp_clock_present,
   output logic [mctm_pkg::TEMPO_W-1:0]               rsp_tempo_tenths_bpm,
   output logic                                       rsp_activity_recent
);

   mctm_pkg::cmd_type cmd;
   mctm_pkg::sts_type sts;

   // Config writes are taken at any time
   assign csr_ready = 1'b1;

   mctm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   mctm_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .csr_valid             (csr_valid),
      .csr_show_clock_events (csr_show_clock_events),
      .req_command           (req_command),
      .req_event_type        (req_event_type),
      .req_channel           (req_channel),
      .req_data_byte         (req_data_byte),
      .req_event_value       (req_event_value),
      .req_now_ms            (req_now_ms),
      .req_now_us            (req_now_us),
      .rsp_shown_type        (rsp_shown_type),
      .rsp_shown_channel     (rsp_shown_channel),
      .rsp_shown_data        (rsp_shown_data),
      .rsp_shown_value       (rsp_shown_value),
      .rsp_event_count       (rsp_event_count),
      .rsp_event_time_ms     (rsp_event_time_ms),
      .rsp_clock_count       (rsp_clock_count),
      .rsp_clock_age_ms      (rsp_clock_age_ms),
      .rsp_clock_present     (rsp_clock_present),
      .rsp_tempo_tenths_bpm  (rsp_tempo_tenths_bpm),
      .rsp_activity_recent   (rsp_activity_recent)
   );

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the MIDI clock tempo monitor: predicted snapshots against DUT.
module testbench;

   localparam int unsigned CYCLE_LIMIT       = 400000;
   localparam int unsigned DRAIN_CYCLES      = 40;
   localparam int unsigned HOLD_OFF_CYCLES   = 400;
   localparam int unsigned HOLD_OFF_AT       = 500;
   localparam int unsigned CLOCKS_PER_BEAT   = 24;
   localparam int unsigned REPORT_LIMIT      = 10;
   localparam int unsigned ITEMS_PER_PHASE   = 600;
   localparam int unsigned STEADY_ITEMS      = 150;
   localparam int unsigned DRAIN_PAUSE_AT    = 300;

   // One request word and one snapshot word as seen on the ports
   typedef struct {
      logic                                command;
      logic [mctm_pkg::TYPE_W-1:0]         event_type;
      logic [mctm_pkg::CHAN_W-1:0]         channel;
      logic [mctm_pkg::DATA_W-1:0]         data_byte;
      logic [mctm_pkg::VALUE_W-1:0]        event_value;
      logic [mctm_pkg::TIME_W-1:0]         now_ms;
      logic [mctm_pkg::TIME_W-1:0]         now_us;
   } request_type;

   typedef struct {
      logic [mctm_pkg::TYPE_W-1:0]         shown_type;
      logic [mctm_pkg::CHAN_W-1:0]         shown_channel;
      logic [mctm_pkg::DATA_W-1:0]         shown_data;
      logic [mctm_pkg::VALUE_W-1:0]        shown_value;
      logic [mctm_pkg::COUNT_W-1:0]        event_count;
      logic [mctm_pkg::TIME_W-1:0]         event_time_ms;
      logic [mctm_pkg::COUNT_W-1:0]        clock_count;
      logic [mctm_pkg::TIME_W-1:0]         clock_age_ms;
      logic                                clock_present;
      logic [mctm_pkg::TEMPO_W-1:0]        tempo_tenths_bpm;
      logic                                activity_recent;
   } snapshot_type;

   // Tempo monitor predictor and the queue of snapshots it expects
   class tempo_scoreboard_type;
      bit                                  show_clocks;
      logic [mctm_pkg::TYPE_W-1:0]         held_type;
      logic [mctm_pkg::CHAN_W-1:0]         held_channel;
      logic [mctm_pkg::DATA_W-1:0]         held_data;
      logic [mctm_pkg::VALUE_W-1:0]        held_value;
      logic [mctm_pkg::COUNT_W-1:0]        held_count;
      logic [mctm_pkg::TIME_W-1:0]         held_time_ms;
      logic [mctm_pkg::TIME_W-1:0]         activity_ms;
      logic [mctm_pkg::COUNT_W-1:0]        clocks_seen;
      logic [mctm_pkg::TIME_W-1:0]         prev_clock_us;
      logic [mctm_pkg::TIME_W-1:0]         prev_clock_ms;
      logic [mctm_pkg::PERIOD_W-1:0]       period_us;
      snapshot_type                        snapshots_due[$];
      int unsigned                         mismatches;
      int unsigned                         results_seen;

      function new();
         show_clocks   = 1'b0;
         held_type     = mctm_pkg::TYPE_NONE;
         held_channel  = '0;
         held_data     = '0;
         held_value    = '0;
         held_count    = '0;
         held_time_ms  = '0;
         activity_ms   = '0;
         clocks_seen   = '0;
         prev_clock_us = '0;
         prev_clock_ms = '0;
         period_us     = '0;
         mismatches    = 0;
         results_seen  = 0;
      endfunction

      function void set_show_clocks(bit value);
         show_clocks = value;
      endfunction

      function int pending();
         return snapshots_due.size();
      endfunction

      // Apply one accepted request and queue the snapshot it produces
      function void note_request(request_type r);
         snapshot_type   s;
         logic [31:0]    delta;
         logic [31:0]    iir_sum;
         logic [31:0]    quotient;
         logic [31:0]    since_activity;
         if (r.command == mctm_pkg::CMD_RECORD) begin
            if (r.event_type == mctm_pkg::TYPE_CLOCK) begin
               // measure the interval only once a previous clock exists
               if (prev_clock_us != 0) begin
                  delta = r.now_us - prev_clock_us;
                  if (delta >= mctm_pkg::MIN_INTERVAL_US
                      && delta <= mctm_pkg::MAX_INTERVAL_US) begin
                     if (period_us == 0) begin
                        period_us = delta[mctm_pkg::PERIOD_W-1:0];
                     end else begin
                        iir_sum   = 32'(period_us) * 7 + delta;
                        period_us = iir_sum[mctm_pkg::PERIOD_W+2:3];
                     end
                  end
               end
               prev_clock_us = r.now_us;
               prev_clock_ms = r.now_ms;
               clocks_seen   = clocks_seen + 1;
            end
            // latch the event unless it is a hidden clock
            if (r.event_type != mctm_pkg::TYPE_CLOCK || show_clocks) begin
               held_type    = r.event_type;
               held_channel = r.channel;
               held_data    = r.data_byte;
               held_value   = r.event_value;
               held_count   = held_count + 1;
               held_time_ms = r.now_ms;
               if (r.event_type != mctm_pkg::TYPE_NONE
                   && r.event_type != mctm_pkg::TYPE_CLOCK) begin
                  activity_ms = r.now_ms;
               end
            end
         end

         s.shown_type    = held_type;
         s.shown_channel = held_channel;
         s.shown_data    = held_data;
         s.shown_value   = held_value;
         s.event_count   = held_count;
         s.event_time_ms = held_time_ms;
         s.clock_count   = clocks_seen;
         s.clock_age_ms  = (prev_clock_ms != 0) ? r.now_ms - prev_clock_ms
                                                : mctm_pkg::AGE_NONE;
         s.clock_present = (prev_clock_ms != 0
                            && s.clock_age_ms < mctm_pkg::PRESENT_WINDOW_MS);
         s.tempo_tenths_bpm = '0;
         if (s.clock_present && period_us != 0) begin
            quotient = 32'(mctm_pkg::TEMPO_DIVIDEND)
                     / (32'(period_us) * CLOCKS_PER_BEAT);
            s.tempo_tenths_bpm = (quotient > 32'(mctm_pkg::TEMPO_MAX))
                               ? mctm_pkg::TEMPO_MAX
                               : quotient[mctm_pkg::TEMPO_W-1:0];
         end
         since_activity    = r.now_ms - activity_ms;
         s.activity_recent = (activity_ms != 0
                              && since_activity < mctm_pkg::ACTIVITY_WINDOW_MS);
         snapshots_due.push_back(s);
      endfunction

      function bit field_differs(string field, logic [31:0] want, logic [31:0] got);
         if (want === got) return 1'b0;
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch on %s in result %0d: expected 0x%08h, got 0x%08h",
                     field, results_seen, want, got);
         end
         return 1'b1;
      endfunction

      // Compare one snapshot from the DUT with the oldest expectation
      function void check_snapshot(snapshot_type got);
         snapshot_type want;
         bit           bad;
         results_seen++;
         if (snapshots_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("unexpected result %0d with no request pending", results_seen);
            end
            return;
         end
         want = snapshots_due.pop_front();
         bad  = 1'b0;
         bad |= field_differs("shown_type", 32'(want.shown_type), 32'(got.shown_type));
         bad |= field_differs("shown_channel", 32'(want.shown_channel),
                              32'(got.shown_channel));
         bad |= field_differs("shown_data", 32'(want.shown_data), 32'(got.shown_data));
         bad |= field_differs("shown_value", 32'(want.shown_value), 32'(got.shown_value));
         bad |= field_differs("event_count", want.event_count, got.event_count);
         bad |= field_differs("event_time_ms", want.event_time_ms, got.event_time_ms);
         bad |= field_differs("clock_count", want.clock_count, got.clock_count);
         bad |= field_differs("clock_age_ms", want.clock_age_ms, got.clock_age_ms);
         bad |= field_differs("clock_present", 32'(want.clock_present),
                              32'(got.clock_present));
         bad |= field_differs("tempo_tenths_bpm", 32'(want.tempo_tenths_bpm),
                              32'(got.tempo_tenths_bpm));
         bad |= field_differs("activity_recent", 32'(want.activity_recent),
                              32'(got.activity_recent));
      endfunction
   endclass

   logic                                   clock;
   logic                                   reset;
   logic                                   csr_valid;
   logic                                   csr_ready;
   logic                                   csr_show_clock_events;
   logic                                   req_valid;
   logic                                   req_ready;
   logic                                   req_command;
   logic [mctm_pkg::TYPE_W-1:0]            req_event_type;
   logic [mctm_pkg::CHAN_W-1:0]            req_channel;
   logic [mctm_pkg::DATA_W-1:0]            req_data_byte;
   logic signed [mctm_pkg::VALUE_W-1:0]    req_event_value;
   logic [mctm_pkg::TIME_W-1:0]            req_now_ms;
   logic [mctm_pkg::TIME_W-1:0]            req_now_us;
   logic                                   rsp_valid;
   logic                                   rsp_ready;
   logic [mctm_pkg::TYPE_W-1:0]            rsp_shown_type;
   logic [mctm_pkg::CHAN_W-1:0]            rsp_shown_channel;
   logic [mctm_pkg::DATA_W-1:0]            rsp_shown_data;
   logic signed [mctm_pkg::VALUE_W-1:0]    rsp_shown_value;
   logic [mctm_pkg::COUNT_W-1:0]           rsp_event_count;
   logic [mctm_pkg::TIME_W-1:0]            rsp_event_time_ms;
   logic [mctm_pkg::COUNT_W-1:0]           rsp_clock_count;
   logic [mctm_pkg::TIME_W-1:0]            rsp_clock_age_ms;
   logic                                   rsp_clock_present;
   logic [mctm_pkg::TEMPO_W-1:0]           rsp_tempo_tenths_bpm;
   logic                                   rsp_activity_recent;

   tempo_scoreboard_type                   sb;
   bit                                     steady;
   int unsigned                            cycle_count;
   logic [mctm_pkg::TIME_W-1:0]            base_ms;
   logic [mctm_pkg::TIME_W-1:0]            base_us;

   midi_clock_tempo_monitor dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_show_clock_events (csr_show_clock_events),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_command           (req_command),
      .req_event_type        (req_event_type),
      .req_channel           (req_channel),
      .req_data_byte         (req_data_byte),
      .req_event_value       (req_event_value),
      .req_now_ms            (req_now_ms),
      .req_now_us            (req_now_us),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_shown_type        (rsp_shown_type),
      .rsp_shown_channel     (rsp_shown_channel),
      .rsp_shown_data        (rsp_shown_data),
      .rsp_shown_value       (rsp_shown_value),
      .rsp_event_count       (rsp_event_count),
      .rsp_event_time_ms     (rsp_event_time_ms),
      .rsp_clock_count       (rsp_clock_count),
      .rsp_clock_age_ms      (rsp_clock_age_ms),
      .rsp_clock_present     (rsp_clock_present),
      .rsp_tempo_tenths_bpm  (rsp_tempo_tenths_bpm),
      .rsp_activity_recent   (rsp_activity_recent)
   );

   // Toggle the clock every half period
   always #2 clock = ~clock;

   // Abort a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** midi_clock_tempo_monitor: FAILED **");
         $finish;
      end
   end

   function int unsigned draw_gap();
      return steady ? 0 : $urandom_range(0, 3);
   endfunction

   // Offer one request word, hold it until accepted, then note it
   task automatic send_request(request_type r);
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= r.command;
      req_event_type  <= r.event_type;
      req_channel     <= r.channel;
      req_data_byte   <= r.data_byte;
      req_event_value <= r.event_value;
      req_now_ms      <= r.now_ms;
      req_now_us      <= r.now_us;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic offer(logic cmd, logic [mctm_pkg::TYPE_W-1:0] kind,
                        logic [mctm_pkg::CHAN_W-1:0] ch,
                        logic [mctm_pkg::DATA_W-1:0] data,
                        logic [mctm_pkg::VALUE_W-1:0] value,
                        logic [mctm_pkg::TIME_W-1:0] ms, logic [mctm_pkg::TIME_W-1:0] us);
      request_type r;
      r.command     = cmd;
      r.event_type  = kind;
      r.channel     = ch;
      r.data_byte   = data;
      r.event_value = value;
      r.now_ms      = ms;
      r.now_us      = us;
      send_request(r);
   endtask

   // Wait until every snapshot is back, then let the block settle
   task automatic wait_drained();
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write the show-clock-events register while the block is idle
   task automatic write_show_clocks(bit value);
      req_valid <= 1'b0;
      wait_drained();
      csr_valid             <= 1'b1;
      csr_show_clock_events <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_show_clocks(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Build one random request on a mostly steady time base
   task automatic next_random_request(output request_type r);
      int unsigned pick;
      logic [31:0] step_us;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         step_us = $urandom_range(mctm_pkg::MIN_INTERVAL_US, mctm_pkg::MAX_INTERVAL_US);
      end else if (pick < 80) begin
         step_us = $urandom_range(0, mctm_pkg::MIN_INTERVAL_US - 1);
      end else if (pick < 88) begin
         step_us = $urandom_range(mctm_pkg::MAX_INTERVAL_US + 1, 1000000);
      end else if (pick < 92) begin
         step_us = 0;
         base_us = $urandom;
         base_ms = $urandom;
      end else begin
         step_us = $urandom_range(0, 20000);
      end
      base_us = base_us + step_us;
      base_ms = base_ms + step_us / 1000 + $urandom_range(0, 1);

      r.channel     = mctm_pkg::CHAN_W'($urandom);
      r.data_byte   = mctm_pkg::DATA_W'($urandom);
      r.event_value = mctm_pkg::VALUE_W'($urandom);
      r.now_ms      = ($urandom_range(0, 99) == 0) ? '0 : base_ms;
      r.now_us      = ($urandom_range(0, 99) == 0) ? '0 : base_us;
      r.command     = mctm_pkg::CMD_RECORD;
      pick          = $urandom_range(0, 99);
      if (pick < 12) begin
         r.command    = mctm_pkg::CMD_QUERY;
         r.event_type = mctm_pkg::TYPE_W'($urandom);
      end else if (pick < 55) begin
         r.event_type = mctm_pkg::TYPE_CLOCK;
      end else if (pick < 62) begin
         r.event_type = mctm_pkg::TYPE_NONE;
      end else begin
         r.event_type = mctm_pkg::TYPE_W'($urandom_range(2, 15));
      end
   endtask

   task automatic run_random(int unsigned count, bit with_drain_pause);
      request_type r;
      for (int unsigned i = 0; i < count; i++) begin
         steady = (i < STEADY_ITEMS) && with_drain_pause;
         if (with_drain_pause && i == DRAIN_PAUSE_AT) begin
            req_valid <= 1'b0;
            while (sb.pending() != 0) @(negedge clock);
         end
         next_random_request(r);
         send_request(r);
      end
      steady = 1'b0;
   endtask

   // Take snapshots with random stalls and one long hold-off
   initial begin
      int unsigned stall;
      bit          held;
      held = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_gap();
         if (!held && sb.results_seen >= HOLD_OFF_AT) begin
            held  = 1'b1;
            stall = HOLD_OFF_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_snapshot('{rsp_shown_type, rsp_shown_channel, rsp_shown_data,
                             rsp_shown_value, rsp_event_count, rsp_event_time_ms,
                             rsp_clock_count, rsp_clock_age_ms, rsp_clock_present,
                             rsp_tempo_tenths_bpm, rsp_activity_recent});
         @(negedge clock);
      end
   end

   // Reset, directed cases, random phases, verdict
   initial begin
      sb                    = new();
      steady                = 1'b0;
      cycle_count           = 0;
      clock                 = 1'b0;
      reset                 = 1'b1;
      csr_valid             = 1'b0;
      csr_show_clock_events = 1'b0;
      req_valid             = 1'b0;
      req_command           = mctm_pkg::CMD_RECORD;
      req_event_type        = mctm_pkg::TYPE_NONE;
      req_channel           = '0;
      req_data_byte         = '0;
      req_event_value       = '0;
      req_now_ms            = '0;
      req_now_us            = '0;
      base_ms               = '0;
      base_us               = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_show_clocks(1'b0);

      // empty state, type none with extreme payload, activity window edges
      offer(mctm_pkg::CMD_QUERY,  mctm_pkg::TYPE_NONE, 4'd0,  8'd0,   16'h0000,
            32'd1000, 32'd1000000);
      offer(mctm_pkg::CMD_RECORD, mctm_pkg::TYPE_NONE, 4'd15, 8'd255, 16'h8000,
            32'd1010, 32'd1010000);
      offer(mctm_pkg::CMD_RECORD, 4'd15,               4'd0,  8'd0,   16'h7FFF,
            32'd1020, 32'd1020000);
      offer(mctm_pkg::CMD_QUERY,  mctm_pkg::TYPE_NONE, 4'd0,  8'd0,   16'h0000,
            32'd1159, 32'd1159000);
      offer(mctm_pkg::CMD_QUERY,  mctm_pkg::TYPE_NONE, 4'd0,  8'd0,   16'h0000,
            32'd1160, 32'd1160000);
      // clock at zero stamps keeps the none marker
      offer(mctm_pkg::CMD_RECORD, mctm_pkg::TYPE_CLOCK, 4'd3, 8'd7,   16'h1234,
            32'd0,    32'd0);
      offer(mctm_pkg::CMD_QUERY,  mctm_pkg::TYPE_NONE,  4'd0, 8'd0,   16'h0000,
            32'd1200, 32'd1200000);
      // interval filter edges and first smoothed interval
      offer(mctm_pkg::CMD_RECORD, mctm_pkg::TYPE_CLOCK, 4'd0, 8'd0,   16'h0000,
            32'd2000, 32'd2000000);
      offer(mctm_pkg::CMD_RECORD, mctm_pkg::TYPE_CLOCK, 4'd0, 8'd0,   16'h0000,
            32'd2005, 32'd2004999);
      offer(mctm_pkg::CMD_RECORD, mctm_pkg::TYPE_CLOCK, 4'd0, 8'd0,   16'h0000,
            32'd2010, 32'd2009999);
      offer(mctm_pkg::CMD_QUERY,  mctm_pkg::TYPE_NONE,  4'd0, 8'd0,   16'h0000,
            32'd2010, 32'd2009999);
      offer(mctm_pkg::CMD_RECORD, mctm_pkg::TYPE_CLOCK, 4'd0, 8'd0,   16'h0000,
            32'd2210, 32'd2209999);
      offer(mctm_pkg::CMD_RECORD, mctm_pkg::TYPE_CLOCK, 4'd0, 8'd0,   16'h0000,
            32'd2410, 32'd2410000);
      // presence window edges
      offer(mctm_pkg::CMD_QUERY,  mctm_pkg::TYPE_NONE,  4'd0, 8'd0,   16'h0000,
            32'd2909, 32'd2909000);
      offer(mctm_pkg::CMD_QUERY,  mctm_pkg::TYPE_NONE,  4'd0, 8'd0,   16'h0000,
            32'd2910, 32'd2910000);
      // activity stamped at zero reads as never
      offer(mctm_pkg::CMD_RECORD, 4'd9,                 4'd5, 8'd60,  16'h0040,
            32'd0,    32'd2950000);
      // wrap of both time bases
      offer(mctm_pkg::CMD_RECORD, mctm_pkg::TYPE_CLOCK, 4'd0, 8'd0,   16'h0000,
            32'hFFFF_FFF0, 32'hFFFF_F000);
      offer(mctm_pkg::CMD_RECORD, mctm_pkg::TYPE_CLOCK, 4'd0, 8'd0,   16'h0000,
            32'h0000_0005, 32'h0000_2000);
      offer(mctm_pkg::CMD_QUERY,  mctm_pkg::TYPE_NONE,  4'd0, 8'd0,   16'h0000,
            32'h0000_0100, 32'h0001_0000);

      // clocks shown as the latched event
      write_show_clocks(1'b1);
      offer(mctm_pkg::CMD_RECORD, mctm_pkg::TYPE_CLOCK, 4'd10, 8'd200, 16'hFFFF,
            32'h0000_0110, 32'h0001_5000);
      offer(mctm_pkg::CMD_RECORD, mctm_pkg::TYPE_NONE,  4'd1,  8'd1,   16'h0000,
            32'h0000_0120, 32'h0001_8000);
      offer(mctm_pkg::CMD_QUERY,  4'd15,                4'd15, 8'd255, 16'hFFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF);

      base_ms = 32'd50000;
      base_us = 32'd50000000;
      run_random(ITEMS_PER_PHASE, 1'b0);
      write_show_clocks(1'b0);
      run_random(ITEMS_PER_PHASE, 1'b1);
      write_show_clocks(1'b1);
      run_random(ITEMS_PER_PHASE, 1'b0);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0d snapshots never arrived", sb.pending());
      end
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("** midi_clock_tempo_monitor: PASSED **");
      end else begin
         $display("** midi_clock_tempo_monitor: FAILED **");
      end
      $finish;
   end

endmodule
